FILE: design/ehs_pkg.sv
`timescale 1ns / 1ps
// Package for the endstop homing sequencer: payload structs, codes, register map.
// No dependencies; used by endstop_homing_sequencer_unit.
package ehs_pkg;

    localparam int POSITION_WIDTH_DEF = 32;
    localparam int FIELD_POS_W        = 32;
    localparam int LEVEL_W            = 11;
    localparam int DRIVE_W            = 12;
    localparam int COUNT_W            = 8;
    localparam int APB_ADDR_W         = 4;
    localparam int APB_DATA_W         = 32;

    localparam logic [LEVEL_W-1:0] LEVEL_MAX       = 11'd1024;
    localparam logic [COUNT_W-1:0] COUNT_MAX       = 8'd255;

    localparam logic [LEVEL_W-1:0] DRIVE_LEVEL_RST = 11'd41;
    localparam logic [COUNT_W-1:0] STALL_TICKS_RST = 8'd30;
    localparam logic [COUNT_W-1:0] ARRIVE_TOL_RST  = 8'd1;

    typedef enum logic [1:0] {
        REG_DRIVE_LEVEL = 2'd0,
        REG_STALL_TICKS = 2'd1,
        REG_ARRIVE_TOL  = 2'd2,
        REG_NONE        = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_SEEK_POS = 2'd1,
        PH_SEEK_NEG = 2'd2,
        PH_TO_MID   = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        MODE_NONE   = 3'd0,
        MODE_LEVEL  = 3'd1,
        MODE_ZERO_I = 3'd2,
        MODE_TARGET = 3'd3,
        MODE_STOP   = 3'd4
    } t_mode;

    typedef struct packed {
        logic                          start_req;
        logic                          abort;
        logic signed [FIELD_POS_W-1:0] position;
    } t_in_item;

    typedef struct packed {
        t_mode                         drive_mode;
        logic signed [DRIVE_W-1:0]     drive_output;
        logic signed [FIELD_POS_W-1:0] target_position;
        t_phase                        phase;
        logic                          zero_encoder;
        logic signed [FIELD_POS_W-1:0] found_positive_end;
        logic signed [FIELD_POS_W-1:0] found_negative_end;
    } t_out_item;

endpackage

FILE: design/endstop_homing_sequencer_unit.sv
`timescale 1ns / 1ps
// Endstop homing sequencer top level: input register, one-pass control logic, result register.
// Depends on ehs_pkg.

// Takes one control tick per clock cycle when the result is not stalled and returns one result
// transaction for each, through the input register, then the result register. Throughput is
// one transaction per cycle when not stalled; all per-tick work is one compare/add pass
// between the two registers. Result stall backs up into the input stall only when both
// registers hold transactions. Registers (APB, byte address 4*i): 0 drive_level, 1 stall_ticks,
// 2 arrive_tolerance; write them only while no transaction is in flight.
module endstop_homing_sequencer_unit #(
    parameter int POSITION_WIDTH = ehs_pkg::POSITION_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  ehs_pkg::t_in_item               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output ehs_pkg::t_out_item              o_out_data,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [ehs_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [ehs_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [ehs_pkg::APB_DATA_W-1:0]  prdata,
    output logic                            pready
);

    localparam int PW    = POSITION_WIDTH;
    localparam int FW    = ehs_pkg::FIELD_POS_W;
    localparam int EXT_W = (PW > FW) ? PW : FW;
    localparam int LW    = ehs_pkg::LEVEL_W;
    localparam int DW    = ehs_pkg::DRIVE_W;
    localparam int CW    = ehs_pkg::COUNT_W;

    // configuration
    logic [LW-1:0] r_drive_level;
    logic [CW-1:0] r_stall_ticks;
    logic [CW-1:0] r_arrive_tol;
    logic          cfg_wr;
    ehs_pkg::t_reg_idx cfg_idx;

    // handshake / pipeline
    logic                r_in_valid;
    ehs_pkg::t_in_item   r_in;
    logic                r_out_valid;
    ehs_pkg::t_out_item  r_out;
    logic                adv;
    logic                fire;

    // state
    ehs_pkg::t_phase        r_phase, n_phase;
    logic [CW-1:0]          r_ctr, n_ctr;
    logic signed [PW-1:0]   r_last, n_last;
    logic signed [PW-1:0]   r_start, n_start;
    logic signed [PW-1:0]   r_pos_end, n_pos_end;
    logic signed [PW-1:0]   r_neg_end, n_neg_end;
    logic signed [PW-1:0]   r_mid, n_mid;

    // datapath
    logic signed [EXT_W-1:0] pos_ext;
    logic signed [PW-1:0]    pos;
    logic [LW-1:0]           level;
    logic signed [DW-1:0]    drv_pos;
    logic signed [DW-1:0]    drv_neg;
    logic signed [PW:0]      end_sum;
    logic signed [PW-1:0]    mid_new;
    logic signed [PW:0]      mid_diff;
    logic [PW:0]             mid_dist;
    logic                    mid_far;
    logic                    stalled;
    logic                    bump_pos;
    logic                    bump_neg;
    logic [CW-1:0]           ctr_inc;
    logic signed [EXT_W-1:0] tgt_ext;
    logic signed [EXT_W-1:0] pend_ext;
    logic signed [EXT_W-1:0] nend_ext;
    ehs_pkg::t_out_item      res;

    // ---------------- configuration port
    assign pready  = 1'b1;
    assign cfg_idx = ehs_pkg::t_reg_idx'(paddr[3:2]);
    assign cfg_wr  = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drive_level <= ehs_pkg::DRIVE_LEVEL_RST;
            r_stall_ticks <= ehs_pkg::STALL_TICKS_RST;
            r_arrive_tol  <= ehs_pkg::ARRIVE_TOL_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                ehs_pkg::REG_DRIVE_LEVEL: r_drive_level <= pwdata[LW-1:0];
                ehs_pkg::REG_STALL_TICKS: r_stall_ticks <= pwdata[CW-1:0];
                ehs_pkg::REG_ARRIVE_TOL:  r_arrive_tol  <= pwdata[CW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            ehs_pkg::REG_DRIVE_LEVEL: prdata = ehs_pkg::APB_DATA_W'(r_drive_level);
            ehs_pkg::REG_STALL_TICKS: prdata = ehs_pkg::APB_DATA_W'(r_stall_ticks);
            ehs_pkg::REG_ARRIVE_TOL:  prdata = ehs_pkg::APB_DATA_W'(r_arrive_tol);
            default:                  prdata = '0;
        endcase
    end

    // ---------------- handshake
    assign adv        = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && adv;
    assign o_in_stall = r_in_valid && !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in <= i_in_data;
        end
    end

    // ---------------- shared datapath
    assign pos_ext  = EXT_W'(r_in.position);
    assign pos      = pos_ext[PW-1:0];
    assign level    = (r_drive_level > ehs_pkg::LEVEL_MAX) ? ehs_pkg::LEVEL_MAX : r_drive_level;
    assign drv_pos  = signed'({1'b0, level});
    assign drv_neg  = -drv_pos;
    assign end_sum  = {r_pos_end[PW-1], r_pos_end} + {pos[PW-1], pos};
    assign mid_new  = end_sum[PW:1];
    assign mid_diff = {pos[PW-1], pos} - {r_mid[PW-1], r_mid};
    assign mid_dist = mid_diff[PW] ? unsigned'(-mid_diff) : unsigned'(mid_diff);
    assign mid_far  = (mid_dist > (PW+1)'(r_arrive_tol)) || (pos == r_neg_end);
    assign stalled  = (r_ctr == r_stall_ticks);
    assign bump_pos = (pos <= r_last) && (pos != r_start);
    assign bump_neg = (pos >= r_last) && (pos != r_pos_end);
    assign ctr_inc  = (r_ctr == ehs_pkg::COUNT_MAX) ? r_ctr : r_ctr + 1'b1;

    // ---------------- next state
    always_comb begin
        n_phase   = r_phase;
        n_ctr     = r_ctr;
        n_last    = pos;
        n_start   = r_start;
        n_pos_end = r_pos_end;
        n_neg_end = r_neg_end;
        n_mid     = r_mid;
        if (r_in.abort) begin
            n_phase = ehs_pkg::PH_IDLE;
            n_ctr   = '0;
        end else begin
            case (r_phase)
                ehs_pkg::PH_IDLE: begin
                    if (r_in.start_req) begin
                        n_start = pos;
                        n_ctr   = '0;
                        n_phase = ehs_pkg::PH_SEEK_POS;
                    end
                end
                ehs_pkg::PH_SEEK_POS: begin
                    if (stalled) begin
                        n_pos_end = pos;
                        n_phase   = ehs_pkg::PH_SEEK_NEG;
                        n_ctr     = '0;
                    end else begin
                        n_ctr = bump_pos ? ctr_inc : '0;
                    end
                end
                ehs_pkg::PH_SEEK_NEG: begin
                    if (stalled) begin
                        n_neg_end = pos;
                        n_mid     = mid_new;
                        n_phase   = ehs_pkg::PH_TO_MID;
                        n_ctr     = '0;
                    end else begin
                        n_ctr = bump_neg ? ctr_inc : '0;
                    end
                end
                ehs_pkg::PH_TO_MID: begin
                    if (!mid_far) begin
                        n_phase = ehs_pkg::PH_IDLE;
                    end
                end
                default: n_phase = ehs_pkg::PH_IDLE;
            endcase
        end
    end

    // ---------------- result
    assign tgt_ext  = EXT_W'(r_mid);
    assign pend_ext = EXT_W'(n_pos_end);
    assign nend_ext = EXT_W'(n_neg_end);

    always_comb begin
        res                    = '0;
        res.drive_mode         = ehs_pkg::MODE_NONE;
        res.phase              = n_phase;
        res.found_positive_end = pend_ext[FW-1:0];
        res.found_negative_end = nend_ext[FW-1:0];
        if (r_in.abort) begin
            res.drive_mode = ehs_pkg::MODE_STOP;
        end else begin
            case (r_phase)
                ehs_pkg::PH_IDLE: begin
                    if (r_in.start_req) begin
                        res.drive_mode   = ehs_pkg::MODE_LEVEL;
                        res.drive_output = drv_pos;
                    end
                end
                ehs_pkg::PH_SEEK_POS: begin
                    res.drive_mode   = ehs_pkg::MODE_LEVEL;
                    res.drive_output = stalled ? drv_neg : drv_pos;
                end
                ehs_pkg::PH_SEEK_NEG: begin
                    if (stalled) begin
                        res.drive_mode = ehs_pkg::MODE_ZERO_I;
                    end else begin
                        res.drive_mode   = ehs_pkg::MODE_LEVEL;
                        res.drive_output = drv_neg;
                    end
                end
                ehs_pkg::PH_TO_MID: begin
                    if (mid_far) begin
                        res.drive_mode      = ehs_pkg::MODE_TARGET;
                        res.target_position = tgt_ext[FW-1:0];
                    end else begin
                        res.zero_encoder = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // ---------------- registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= ehs_pkg::PH_IDLE;
            r_ctr     <= '0;
            r_last    <= '0;
            r_start   <= '0;
            r_pos_end <= '0;
            r_neg_end <= '0;
            r_mid     <= '0;
        end else if (fire) begin
            r_phase   <= n_phase;
            r_ctr     <= n_ctr;
            r_last    <= n_last;
            r_start   <= n_start;
            r_pos_end <= n_pos_end;
            r_neg_end <= n_neg_end;
            r_mid     <= n_mid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

FILE: sim/tb.sv
`timescale 1ns / 1ps
// Testbench for endstop_homing_sequencer_unit: homing runs, noise and config sweeps, self-checked.
// Depends on ehs_pkg and the unit; no files or arguments needed.
module tb;
    import ehs_pkg::*;

    localparam int QUIET_LIMIT = 4000;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_in_valid;
    logic                   o_in_stall;
    t_in_item               i_in_data;
    logic                   o_out_valid;
    logic                   i_out_stall;
    t_out_item              o_out_data;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    endstop_homing_sequencer_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // tick stimulus and expected results
    t_in_item  tick_queue[$];
    t_out_item due_results[$];
    int        mismatch_cnt = 0;
    int        quiet_cycles = 0;
    int        send_idle_pct = 0;
    int        recv_stall_pct = 0;

    // predictor config and state
    logic [LEVEL_W-1:0]  cfg_level = DRIVE_LEVEL_RST;
    logic [COUNT_W-1:0]  cfg_stall = STALL_TICKS_RST;
    logic [COUNT_W-1:0]  cfg_tol   = ARRIVE_TOL_RST;
    t_phase              hm_phase  = PH_IDLE;
    logic [COUNT_W-1:0]  stall_cnt = '0;
    logic signed [31:0]  prev_pos  = '0;
    logic signed [31:0]  origin_pos = '0;
    logic signed [31:0]  pos_end   = '0;
    logic signed [31:0]  neg_end   = '0;
    logic signed [31:0]  mid_tgt   = '0;

    function automatic void stall_step(logic no_progress);
        if (!no_progress)
            stall_cnt = '0;
        else if (stall_cnt != COUNT_MAX)
            stall_cnt = stall_cnt + 1'b1;
    endfunction

    function automatic t_out_item advance_homing(t_in_item it);
        t_out_item          r;
        logic signed [31:0] pos;
        logic signed [11:0] lvl;
        longint             gap;
        pos = it.position;
        lvl = (cfg_level > LEVEL_MAX) ? 12'sd1024 : $signed({1'b0, cfg_level});
        r = '0;
        r.drive_mode = MODE_NONE;
        if (it.abort) begin
            r.drive_mode = MODE_STOP;
            hm_phase = PH_IDLE;
            stall_cnt = '0;
        end else begin
            case (hm_phase)
                PH_IDLE: begin
                    if (it.start_req) begin
                        origin_pos = pos;
                        stall_cnt = '0;
                        hm_phase = PH_SEEK_POS;
                        r.drive_mode = MODE_LEVEL;
                        r.drive_output = lvl;
                    end
                end
                PH_SEEK_POS: begin
                    r.drive_mode = MODE_LEVEL;
                    if (stall_cnt == cfg_stall) begin
                        pos_end = pos;
                        hm_phase = PH_SEEK_NEG;
                        stall_cnt = '0;
                        r.drive_output = -lvl;
                    end else begin
                        r.drive_output = lvl;
                        stall_step(pos <= prev_pos && pos != origin_pos);
                    end
                end
                PH_SEEK_NEG: begin
                    if (stall_cnt == cfg_stall) begin
                        neg_end = pos;
                        mid_tgt = 32'((longint'(pos_end) + longint'(pos)) >>> 1);
                        hm_phase = PH_TO_MID;
                        stall_cnt = '0;
                        r.drive_mode = MODE_ZERO_I;
                    end else begin
                        r.drive_mode = MODE_LEVEL;
                        r.drive_output = -lvl;
                        stall_step(pos >= prev_pos && pos != pos_end);
                    end
                end
                default: begin
                    gap = longint'(pos) - longint'(mid_tgt);
                    if (gap < 0)
                        gap = -gap;
                    if (gap > longint'(cfg_tol) || pos == neg_end) begin
                        r.drive_mode = MODE_TARGET;
                        r.target_position = mid_tgt;
                    end else begin
                        r.zero_encoder = 1'b1;
                        hm_phase = PH_IDLE;
                    end
                end
            endcase
        end
        prev_pos = pos;
        r.phase = hm_phase;
        r.found_positive_end = pos_end;
        r.found_negative_end = neg_end;
        return r;
    endfunction

    function automatic t_in_item ctl_tick(logic s, logic a, logic signed [31:0] p);
        t_in_item t;
        t.start_req = s;
        t.abort = a;
        t.position = p;
        return t;
    endfunction

    function automatic int pick_origin();
        case ($urandom_range(0, 7))
            0: return 32'h7fff_fff0;
            1: return 32'h8000_0000;
            2: return 0;
            3: return $urandom_range(0, 2000) - 1000;
            default: return $urandom;
        endcase
    endfunction

    // One homing run shaped to the current stall setting, occasionally corrupted.
    function automatic int queue_homing_run();
        t_in_item seq[$];
        int       p;
        int       pend;
        int       nend;
        int       mid;
        int       off;
        int       k;
        longint   f;
        p = pick_origin();
        seq.push_back(ctl_tick(1'b1, 1'b0, p));
        repeat ($urandom_range(1, 6)) begin
            p = p + $urandom_range(1, 400);
            seq.push_back(ctl_tick(1'b0, 1'b0, p));
        end
        repeat (cfg_stall + 1 + $urandom_range(0, 2)) begin
            if ($urandom_range(0, 7) == 0)
                p = p - 1;
            seq.push_back(ctl_tick(1'b0, 1'b0, p));
        end
        pend = p;
        repeat ($urandom_range(1, 6)) begin
            p = p - $urandom_range(1, 400);
            seq.push_back(ctl_tick(1'b0, 1'b0, p));
        end
        repeat (cfg_stall + 1 + $urandom_range(0, 2)) begin
            if ($urandom_range(0, 7) == 0)
                p = p + 1;
            seq.push_back(ctl_tick(1'b0, 1'b0, p));
        end
        nend = p;
        mid = int'((longint'(pend) + longint'(nend)) >>> 1);
        repeat ($urandom_range(0, 3))
            seq.push_back(ctl_tick(1'b0, 1'b0, $urandom_range(0, 1) ? nend : int'($urandom)));
        off = $urandom_range(0, cfg_tol);
        f = longint'(mid) + ($urandom_range(0, 1) ? -off : off);
        if (f != longint'(int'(f)))
            f = mid;
        seq.push_back(ctl_tick(1'b0, 1'b0, int'(f)));
        if (int'(f) == nend)
            seq.push_back(ctl_tick(1'b0, 1'b0, mid));
        if (mid == nend)
            seq.push_back(ctl_tick(1'b0, 1'b1, mid));
        if ($urandom_range(0, 9) == 0) begin
            k = $urandom_range(0, seq.size() - 1);
            seq[k].abort = 1'b1;
        end
        if ($urandom_range(0, 7) == 0) begin
            k = $urandom_range(1, seq.size() - 1);
            seq[k].start_req = 1'b1;
        end
        foreach (seq[i])
            tick_queue.push_back(seq[i]);
        return seq.size();
    endfunction

    function automatic int queue_noise(int n);
        repeat (n)
            tick_queue.push_back(ctl_tick($urandom_range(0, 3) == 0, $urandom_range(0, 7) == 0,
                                          $urandom));
        return n;
    endfunction

    task automatic reg_write(t_reg_idx idx, logic [APB_DATA_W-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_DRIVE_LEVEL: cfg_level = val[LEVEL_W-1:0];
            REG_STALL_TICKS: cfg_stall = val[COUNT_W-1:0];
            REG_ARRIVE_TOL:  cfg_tol   = val[COUNT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic drain();
        while (tick_queue.size() != 0 || i_in_valid || due_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic set_idling(int sel);
        case (sel)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
            default: begin send_idle_pct = 6; recv_stall_pct = 6; end
        endcase
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // driver: accepted transaction updates the predictor, then the next tick is offered
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && !o_in_stall)
                due_results.push_back(advance_homing(i_in_data));
            if (!i_in_valid || !o_in_stall) begin
                if (tick_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    i_in_data  <= tick_queue.pop_front();
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else begin
            if (o_out_valid && !i_out_stall) begin
                if (due_results.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected result transaction: %p", o_out_data);
                end else begin
                    want = due_results.pop_front();
                    if (o_out_data !== want) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10) begin
                            $display("mismatch: exp mode=%0d out=%0d tgt=%0d ph=%0d zero=%0b pos=%0d neg=%0d",
                                     want.drive_mode, want.drive_output, want.target_position,
                                     want.phase, want.zero_encoder, want.found_positive_end,
                                     want.found_negative_end);
                            $display("          got mode=%0d out=%0d tgt=%0d ph=%0d zero=%0b pos=%0d neg=%0d",
                                     o_out_data.drive_mode, o_out_data.drive_output,
                                     o_out_data.target_position, o_out_data.phase,
                                     o_out_data.zero_encoder, o_out_data.found_positive_end,
                                     o_out_data.found_negative_end);
                        end
                    end
                end
            end
            i_out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall) || psel)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("endstop_homing_sequencer_unit test failed");
            $finish;
        end
    end

    initial begin
        int lvl;
        int stl;
        int tol;
        int quota;
        int pushed;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_out_stall = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: immediate confirm, saturated level, exact arrival
        set_idling(0);
        reg_write(REG_DRIVE_LEVEL, 32'd2047);
        reg_write(REG_STALL_TICKS, 32'd0);
        reg_write(REG_ARRIVE_TOL, 32'd0);
        tick_queue.push_back(ctl_tick(1'b0, 1'b0, 32'sd0));
        tick_queue.push_back(ctl_tick(1'b0, 1'b1, 32'h7fff_ffff));
        tick_queue.push_back(ctl_tick(1'b1, 1'b1, 32'h8000_0000));
        tick_queue.push_back(ctl_tick(1'b1, 1'b0, 32'h7fff_ffff));
        tick_queue.push_back(ctl_tick(1'b1, 1'b0, 32'h7fff_ffff));
        tick_queue.push_back(ctl_tick(1'b0, 1'b0, 32'h8000_0000));
        tick_queue.push_back(ctl_tick(1'b0, 1'b0, 32'h8000_0000));
        tick_queue.push_back(ctl_tick(1'b0, 1'b0, 32'sd5));
        tick_queue.push_back(ctl_tick(1'b0, 1'b0, -32'sd1));
        tick_queue.push_back(ctl_tick(1'b1, 1'b0, 32'sd100));
        tick_queue.push_back(ctl_tick(1'b0, 1'b0, 32'sd100));
        tick_queue.push_back(ctl_tick(1'b0, 1'b1, 32'sd7));
        tick_queue.push_back(ctl_tick(1'b1, 1'b0, -32'sd5));
        tick_queue.push_back(ctl_tick(1'b0, 1'b0, -32'sd5));
        tick_queue.push_back(ctl_tick(1'b0, 1'b0, -32'sd6));
        tick_queue.push_back(ctl_tick(1'b0, 1'b0, -32'sd6));
        tick_queue.push_back(ctl_tick(1'b0, 1'b0, -32'sd7));
        tick_queue.push_back(ctl_tick(1'b0, 1'b1, 32'sd0));
        tick_queue.push_back(ctl_tick(1'b1, 1'b0, 32'sd1));
        tick_queue.push_back(ctl_tick(1'b0, 1'b1, 32'sd2));
        drain();

        for (int ph_i = 1; ph_i <= 8; ph_i++) begin
            case (ph_i)
                1: begin lvl = 41;   stl = 3;   tol = 1;   end
                2: begin lvl = 1024; stl = 1;   tol = 0;   end
                3: begin lvl = 0;    stl = 0;   tol = 255; end
                5: begin lvl = 700;  stl = 255; tol = 3;   end
                6: begin
                    lvl = $urandom_range(0, 2047);
                    stl = $urandom_range(1, 8);
                    tol = 255;
                end
                default: begin
                    lvl = $urandom_range(0, 2047);
                    stl = $urandom_range(0, 12);
                    tol = $urandom_range(0, 20);
                end
            endcase
            set_idling(ph_i % 4);
            reg_write(REG_DRIVE_LEVEL, lvl);
            reg_write(REG_STALL_TICKS, stl);
            reg_write(REG_ARRIVE_TOL, tol);
            quota = (stl == 255) ? 1 : 120;
            pushed = 0;
            while (pushed < quota) begin
                if (stl == 255 || $urandom_range(0, 9) < 8)
                    pushed += queue_homing_run();
                else
                    pushed += queue_noise($urandom_range(1, 5));
            end
            // leave the block idle before the next register writes
            tick_queue.push_back(ctl_tick(1'b0, 1'b1, $urandom));
            drain();
        end

        if (mismatch_cnt == 0 && due_results.size() == 0)
            $display("endstop_homing_sequencer_unit test passed");
        else
            $display("endstop_homing_sequencer_unit test failed");
        $finish;
    end

endmodule
